>>> src/depth_grid_mesh_triangulator_core_defines.svh
// Assertion helpers shared by the triangulator sources.
`ifndef DEPTH_GRID_MESH_TRIANGULATOR_CORE_DEFINES_SVH
`define DEPTH_GRID_MESH_TRIANGULATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/dgmt_pkg.sv
package dgmt_pkg;

	localparam int CFG_DIM_W = 10;
	localparam int DEPTH_W   = 16;
	localparam int NUM_W     = 18;
	localparam int TOTAL_W   = 19;
	localparam int POS_W     = 9;

	localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RESET  = 10'd480;
	localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RESET = 10'd360;
	localparam logic [DEPTH_W-1:0]   DEPTH_LIMIT_RESET  = 16'(65535 / 80);

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH_LIMIT  = 2'd2;

	// result slots of one pixel, in delivery order
	localparam int SLOTS        = 4;
	localparam int SLOT_VERTEX  = 0;
	localparam int SLOT_TRI_A   = 1;
	localparam int SLOT_TRI_B   = 2;
	localparam int SLOT_SUMMARY = 3;

	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_SUMMARY  = 2'd2
	} kind_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
	} pixel_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   column;
		logic [POS_W-1:0]   row;
		logic [DEPTH_W-1:0] vertex_depth;
		logic [NUM_W-1:0]   corner_one;
		logic [NUM_W-1:0]   corner_two;
		logic [NUM_W-1:0]   corner_three;
		logic [TOTAL_W-1:0] vertex_total;
		logic [TOTAL_W-1:0] triangle_total;
	} result_t;

	typedef struct packed {
		result_t [SLOTS-1:0] slot;
		logic [SLOTS-1:0]    mask;
	} bundle_t;

endpackage

>>> src/dgmt_row_store.sv
module dgmt_row_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     wr_addr,
	input  dgmt_pkg::pixel_t  wr_data,
	input  logic [AW-1:0]     rd_addr,
	output dgmt_pkg::pixel_t  rd_data
);
	import dgmt_pkg::*;

	pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/dgmt_quad.sv
module dgmt_quad (
	input  logic              en,
	input  dgmt_pkg::pixel_t  a,
	input  dgmt_pkg::pixel_t  b,
	input  dgmt_pkg::pixel_t  c,
	input  dgmt_pkg::pixel_t  d,
	output dgmt_pkg::result_t first_tri,
	output dgmt_pkg::result_t second_tri,
	output logic [1:0]        tri_valid
);
	import dgmt_pkg::*;

	logic prim_cba, prim_cdb, fall_dba, fall_cda, any_prim;

	function automatic result_t make_tri(pixel_t p, pixel_t q, pixel_t s);
		result_t r;
		r              = '0;
		r.kind         = KIND_TRIANGLE;
		r.corner_one   = p.num;
		r.corner_two   = q.num;
		r.corner_three = s.num;
		return r;
	endfunction

	always_comb begin
		prim_cba = en && a.valid && b.valid && c.valid;
		prim_cdb = en && c.valid && d.valid && b.valid;
		any_prim = prim_cba || prim_cdb;
		// fallback diagonal only when no primary triangle was made
		fall_dba = en && !any_prim && a.valid && b.valid && d.valid;
		fall_cda = en && !any_prim && c.valid && d.valid && a.valid;

		if (prim_cba) begin
			first_tri = make_tri(c, b, a);
		end else if (prim_cdb) begin
			first_tri = make_tri(c, d, b);
		end else if (fall_dba) begin
			first_tri = make_tri(d, b, a);
		end else begin
			first_tri = make_tri(c, d, a);
		end

		if (prim_cba) begin
			second_tri = make_tri(c, d, b);
		end else begin
			second_tri = make_tri(c, d, a);
		end

		tri_valid[0] = any_prim || fall_dba || fall_cda;
		tri_valid[1] = (prim_cba && prim_cdb) || (fall_dba && fall_cda);
	end

endmodule

>>> src/dgmt_serializer.sv
`include "depth_grid_mesh_triangulator_core_defines.svh"

module dgmt_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  dgmt_pkg::bundle_t  bundle,
	output logic               free,
	output logic               out_valid,
	input  logic               out_stall,
	output dgmt_pkg::result_t  out_res,
	output logic               out_last
);
	import dgmt_pkg::*;

	logic [SLOTS-1:0]    mask_s2;
	result_t [SLOTS-1:0] slot_s2;
	logic [1:0]          pick_idx;
	logic [SLOTS-1:0]    pick_oh;
	logic [SLOTS-1:0]    rest;
	logic                last_pick;
	logic                out_free;
	logic                emit;

	always_comb begin
		if (mask_s2[0]) begin
			pick_idx = 2'd0;
		end else if (mask_s2[1]) begin
			pick_idx = 2'd1;
		end else if (mask_s2[2]) begin
			pick_idx = 2'd2;
		end else begin
			pick_idx = 2'd3;
		end
		pick_oh   = SLOTS'(1) << pick_idx;
		rest      = mask_s2 & ~pick_oh;
		last_pick = (rest == '0);
		out_free  = !out_valid || !out_stall;
		emit      = (mask_s2 != '0) && out_free;
		// the bundle slot frees once its final result moves to the output
		free      = (mask_s2 == '0) || (emit && last_pick);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				mask_s2 <= bundle.mask;
			end else if (emit) begin
				mask_s2 <= rest;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_free) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_s2 <= bundle.slot;
		end
		if (emit) begin
			out_res  <= slot_s2[pick_idx];
			out_last <= last_pick;
		end
	end

	`ASSERT_IMPLIES(a_summary_last, clk, arst_n, out_valid && (out_res.kind == KIND_SUMMARY), out_last)
	`ASSERT_NEXT(a_pending_moves, clk, arst_n, (mask_s2 != '0) && !out_valid, out_valid)

endmodule

>>> src/depth_grid_mesh_triangulator_core.sv
// Depth-frame triangulator.
// Input channel (in_valid / in_stall, field depth) takes one depth pixel per
// transfer, in raster order. Output channel (out_valid / out_stall) delivers
// result records one per transfer: a vertex record for a valid pixel, up to
// two triangle records when the pixel closes a 2x2 quad, and a summary record
// after the last pixel of the frame; last marks the final record of a pixel.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes frame
// width, frame height and depth limit; cfg_ready is always high.
// Records pass the input register, the bundle register and the output
// register. A pixel has n <= 4 records, which the single result register drains
// from the per-pixel bundle; the next pixel loads as its last record leaves.
// Pixels with no record stream at one per cycle while no records are draining.
// Reset clears the counters, the neighbor pixels and the handshake state and
// loads the register defaults; the previous-row memory needs no clearing,
// since each entry is written on row zero before it is read.
// While out_stall is high the output record holds; one pending bundle and one
// input pixel are held behind it, then in_stall rises.
`include "depth_grid_mesh_triangulator_core_defines.svh"

module depth_grid_mesh_triangulator_core #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] depth,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [8:0]  column,
	output logic [8:0]  row,
	output logic [15:0] vertex_depth,
	output logic [17:0] corner_one,
	output logic [17:0] corner_two,
	output logic [17:0] corner_three,
	output logic [18:0] vertex_total,
	output logic [18:0] triangle_total,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dgmt_pkg::*;

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;
	localparam int YW = (RW + 1 > CFG_DIM_W) ? RW + 1 : CFG_DIM_W;

	logic [CFG_DIM_W-1:0] fw_q, fh_q;
	logic [DEPTH_W-1:0]   limit_q;

	logic                 pix_v_s1;
	logic [DEPTH_W-1:0]   depth_s1;

	logic [CW-1:0]        col_q, col_next, rd_addr;
	logic [RW-1:0]        row_q;
	logic [TOTAL_W-1:0]   vcount_q, tcount_q, vt_next, tt_next;
	pixel_t               left_q, upl_q, up_rd, cur;

	logic                 s2_free, move;
	logic                 vd, quad_en, row_end, frame_end;
	logic [XW-1:0]        col_inc;
	logic [YW-1:0]        row_inc;
	logic [1:0]           tri_valid, ntri;
	result_t              first_tri, second_tri, out_res;
	bundle_t              bundle;

	assign cfg_ready = 1'b1;
	assign move      = pix_v_s1 && s2_free;
	assign in_stall  = pix_v_s1 && !s2_free;

	always_comb begin
		vd        = (depth_s1 != '0) && (depth_s1 < limit_q);
		cur.valid = vd;
		cur.num   = vd ? vcount_q[NUM_W-1:0] : '0;
		quad_en   = (col_q != '0) && (row_q != '0);

		// effective dimension is the register clamped to [2, MAX]
		col_inc   = XW'(col_q) + XW'(1);
		row_inc   = YW'(row_q) + YW'(1);
		row_end   = (col_q != '0) &&
			((col_inc >= XW'(fw_q)) || (col_inc >= XW'(MAX_WIDTH)));
		frame_end = row_end && (row_q != '0) &&
			((row_inc >= YW'(fh_q)) || (row_inc >= YW'(MAX_HEIGHT)));
		col_next  = row_end ? '0 : col_q + CW'(1);
		rd_addr   = move ? col_next : col_q;

		ntri    = 2'(tri_valid[0]) + 2'(tri_valid[1]);
		vt_next = vcount_q + TOTAL_W'(vd);
		tt_next = tcount_q + TOTAL_W'(ntri);

		bundle = '0;
		bundle.slot[SLOT_VERTEX].kind         = KIND_VERTEX;
		bundle.slot[SLOT_VERTEX].column       = POS_W'(col_q);
		bundle.slot[SLOT_VERTEX].row          = POS_W'(row_q);
		bundle.slot[SLOT_VERTEX].vertex_depth = depth_s1;
		bundle.slot[SLOT_TRI_A]               = first_tri;
		bundle.slot[SLOT_TRI_B]               = second_tri;
		bundle.slot[SLOT_SUMMARY].kind           = KIND_SUMMARY;
		bundle.slot[SLOT_SUMMARY].vertex_total   = vt_next;
		bundle.slot[SLOT_SUMMARY].triangle_total = tt_next;
		bundle.mask[SLOT_VERTEX]  = vd;
		bundle.mask[SLOT_TRI_A]   = tri_valid[0];
		bundle.mask[SLOT_TRI_B]   = tri_valid[1];
		bundle.mask[SLOT_SUMMARY] = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= FRAME_WIDTH_RESET;
			fh_q     <= FRAME_HEIGHT_RESET;
			limit_q  <= DEPTH_LIMIT_RESET;
			pix_v_s1 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			vcount_q <= '0;
			tcount_q <= '0;
			left_q   <= '0;
			upl_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  fw_q    <= cfg_data[CFG_DIM_W-1:0];
					REG_FRAME_HEIGHT: fh_q    <= cfg_data[CFG_DIM_W-1:0];
					REG_DEPTH_LIMIT:  limit_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				pix_v_s1 <= 1'b1;
			end else if (move) begin
				pix_v_s1 <= 1'b0;
			end

			if (move) begin
				col_q  <= col_next;
				left_q <= cur;
				upl_q  <= up_rd;
				if (frame_end) begin
					row_q    <= '0;
					vcount_q <= '0;
					tcount_q <= '0;
				end else begin
					if (row_end) begin
						row_q <= row_q + RW'(1);
					end
					vcount_q <= vt_next;
					tcount_q <= tt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			depth_s1 <= depth;
		end
	end

	// read address tracks the next column so the entry is ready when it moves
	dgmt_row_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_row_store (
		.clk     (clk),
		.we      (move),
		.wr_addr (col_q),
		.wr_data (cur),
		.rd_addr (rd_addr),
		.rd_data (up_rd)
	);

	dgmt_quad u_quad (
		.en         (quad_en),
		.a          (upl_q),
		.b          (up_rd),
		.c          (left_q),
		.d          (cur),
		.first_tri  (first_tri),
		.second_tri (second_tri),
		.tri_valid  (tri_valid)
	);

	dgmt_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move),
		.bundle    (bundle),
		.free      (s2_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.out_last  (last)
	);

	assign kind           = out_res.kind;
	assign column         = out_res.column;
	assign row            = out_res.row;
	assign vertex_depth   = out_res.vertex_depth;
	assign corner_one     = out_res.corner_one;
	assign corner_two     = out_res.corner_two;
	assign corner_three   = out_res.corner_three;
	assign vertex_total   = out_res.vertex_total;
	assign triangle_total = out_res.triangle_total;

	`ASSERT_NEXT(a_frame_restart, clk, arst_n, move && frame_end, (col_q == '0) && (row_q == '0) && (vcount_q == '0))
	`ASSERT_IMPLIES(a_tri_order, clk, arst_n, tri_valid[1], tri_valid[0] && quad_en)

endmodule
